[rtl/mlf_pkg.sv]
package mlf_pkg;

   localparam int MAC_W        = 48;
   localparam int PORT_W       = 8;
   localparam int LEN_W        = 14;
   localparam int GROUP_BIT    = 40;
   localparam int MIN_HEADER   = 14;

   localparam int REQ_PORT_LO  = 0;
   localparam int REQ_LEN_LO   = REQ_PORT_LO + PORT_W;
   localparam int REQ_SRC_LO   = REQ_LEN_LO + LEN_W;
   localparam int REQ_DST_LO   = REQ_SRC_LO + MAC_W;
   localparam int REQ_USED_W   = REQ_DST_LO + MAC_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_VERDICT_LO = 0;
   localparam int RSP_LEARNED    = 2;
   localparam int RSP_EVICTED    = 3;
   localparam int RSP_DATA_W     = 8;

   typedef enum logic [1:0] {
      VERDICT_PASS       = 2'd0,
      VERDICT_DROP_LOOP  = 2'd1,
      VERDICT_DROP_GROUP = 2'd2
   } verdict_type;

   typedef enum logic {
      MODE_INGRESS = 1'b0,
      MODE_EGRESS  = 1'b1
   } mode_type;

endpackage

[rtl/mlf_ram.sv]
module mlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mlf_set_unit.sv]
module mlf_set_unit #(
   parameter int NUM_SETS = 256
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   input  logic [mlf_pkg::MAC_W-1:0]                        mac,
   output logic                                             done,
   output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] set_index
);
   import mlf_pkg::*;

   localparam int SET_W = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;

   logic [MAC_W-1:0] fold1;
   logic [MAC_W-1:0] fold;

   assign fold1 = mac ^ (mac >> 24);
   assign fold  = fold1 ^ (fold1 >> 12);

   if ((NUM_SETS & (NUM_SETS - 1)) == 0) begin : g_mask
      assign done      = start;
      assign set_index = fold[SET_W-1:0];
   end else begin : g_serial
      // remainder by reciprocal multiplication, 16 key bits per step, MSB first;
      // each step runs a quotient estimate phase, then a remainder phase
      localparam int CHUNK_W = 16;
      localparam int STEPS   = MAC_W / CHUNK_W;
      localparam int V_W     = SET_W + CHUNK_W;
      localparam int SHIFT   = V_W + SET_W;
      localparam int RECIP_W = V_W + 2;
      localparam int PROD_W  = V_W + RECIP_W;
      localparam longint unsigned RECIP =
         ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);

      logic [MAC_W-1:0]   shift_ff, shift_in;
      logic [SET_W-1:0]   rem_ff, rem_in;
      logic [V_W-1:0]     part_ff, part_in;
      logic [CHUNK_W-1:0] quot_ff, quot_in;
      logic [1:0]         step_ff, step_in;
      logic               phase_ff, phase_in;
      logic               busy_ff, busy_in;
      logic               done_ff, done_in;
      logic [V_W-1:0]     part;
      logic [PROD_W-1:0]  prod;
      logic [V_W-1:0]     back;

      always_comb begin
         shift_in = shift_ff;
         rem_in   = rem_ff;
         part_in  = part_ff;
         quot_in  = quot_ff;
         step_in  = step_ff;
         phase_in = phase_ff;
         busy_in  = busy_ff;
         done_in  = 1'b0;
         part     = {rem_ff, shift_ff[MAC_W-1 -: CHUNK_W]};
         prod     = PROD_W'(part) * PROD_W'(RECIP_W'(RECIP));
         back     = part_ff - V_W'(quot_ff) * V_W'(NUM_SETS);
         if (start) begin
            shift_in = fold;
            rem_in   = '0;
            step_in  = '0;
            phase_in = 1'b0;
            busy_in  = 1'b1;
         end else if (busy_ff) begin
            if (!phase_ff) begin
               part_in  = part;
               quot_in  = prod[SHIFT +: CHUNK_W];
               shift_in = {shift_ff[MAC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
               phase_in = 1'b1;
            end else begin
               rem_in   = back[SET_W-1:0];
               step_in  = step_ff + 1'b1;
               phase_in = 1'b0;
               if (step_ff == 2'(STEPS - 1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b0;
         end else begin
            busy_ff <= busy_in;
            done_ff <= done_in;
         end
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
         part_ff  <= part_in;
         quot_ff  <= quot_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end

      assign done      = done_ff;
      assign set_index = rem_ff;
   end

endmodule

[rtl/mac_loopback_filter_learning.sv]
// Loop filter with source-MAC learning for an active-backup bond. Egress items
// learn their source MAC into a set-associative table (tree pseudo-LRU per set);
// ingress items on the active port are dropped when their source MAC is known,
// ingress items on other ports are dropped when group-addressed. Each set is one
// row of a single synchronous RAM holding the tags, valid bits and recency bits.
// An item's row is read as it is accepted when TABLE_ENTRIES / TABLE_WAYS is a
// power of two; the lookup state then forms the result and writes the row back.
// Otherwise the set index comes from a serial reciprocal remainder unit first.
// A result not yet taken holds the item in the lookup until rsp_tready. After
// reset a clearing pass over the TABLE_ENTRIES / TABLE_WAYS rows runs with
// req_tready low; csr writes are taken at any time.
module mac_loopback_filter_learning #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int TABLE_WAYS    = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // port, frame_length, source_mac, dest_mac, zero pad
   input  logic [mlf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // verdict, learned, evicted, zero pad
   output logic [mlf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [mlf_pkg::PORT_W-1:0]      csr_wdata
);
   import mlf_pkg::*;

   localparam int NUM_SETS = TABLE_ENTRIES / TABLE_WAYS;
   localparam int SET_W    = NUM_SETS > 1 ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W    = TABLE_WAYS > 1 ? $clog2(TABLE_WAYS) : 1;
   localparam int LEAVES   = TABLE_WAYS <= 1 ? 1 : TABLE_WAYS <= 2 ? 2 :
                             TABLE_WAYS <= 4 ? 4 : 8;
   localparam int LEVELS   = $clog2(LEAVES);
   localparam int RW       = LEAVES > 1 ? LEAVES - 1 : 1;
   localparam int VALID_LO = TABLE_WAYS * MAC_W;
   localparam int REC_LO   = VALID_LO + TABLE_WAYS;
   localparam int ROW_W    = REC_LO + RW;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_LOOK
   } state_type;

   state_type               state_ff, state_in;
   logic [SET_W-1:0]        clr_ff, clr_in;
   logic [SET_W-1:0]        set_ff, set_in;
   logic                    mode_ff, mode_in;
   logic [PORT_W-1:0]       port_ff, port_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [MAC_W-1:0]        src_ff, src_in;
   logic [MAC_W-1:0]        dst_ff, dst_in;
   logic [PORT_W-1:0]       bond_port_ff, bond_port_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    set_done;
   logic [SET_W-1:0]        set_idx;
   logic                    wr_en;
   logic [SET_W-1:0]        wr_addr;
   logic [ROW_W-1:0]        wr_data;
   logic [ROW_W-1:0]        row;
   logic [ROW_W-1:0]        row_new;

   logic                    hit_any, free_any;
   logic [WAY_W-1:0]        hit_way, free_way, way_sel;
   logic                    short_frame, on_active;
   logic                    learn, refresh, group_drop, evict;
   verdict_type             verdict;
   logic                    out_free;

   function automatic logic [RW-1:0] touch_f(input logic [RW-1:0] bits_in,
                                             input logic [WAY_W-1:0] way);
      logic [7:0] bits;
      int         node;
      int         base;
      int         span;
      int         half;
      bits = 8'(bits_in);
      node = 1;
      base = 0;
      span = LEAVES;
      for (int l = 0; l < LEVELS; l++) begin
         half = span >> 1;
         if (int'(way) < base + half) begin
            bits[3'(node - 1)] = 1'b1;
            node = 2 * node;
         end else begin
            bits[3'(node - 1)] = 1'b0;
            base = base + half;
            node = 2 * node + 1;
         end
         span = half;
      end
      return bits[RW-1:0];
   endfunction

   function automatic logic [WAY_W-1:0] victim_f(input logic [RW-1:0] bits_in);
      logic [7:0] bits;
      int         node;
      int         base;
      int         span;
      int         half;
      bits = 8'(bits_in);
      node = 1;
      base = 0;
      span = LEAVES;
      for (int l = 0; l < LEVELS; l++) begin
         half = span >> 1;
         if (bits[3'(node - 1)] && (base + half < TABLE_WAYS)) begin
            base = base + half;
            node = 2 * node + 1;
         end else begin
            node = 2 * node;
         end
         span = half;
      end
      return WAY_W'(base);
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   mlf_set_unit #(
      .NUM_SETS (NUM_SETS)
   ) u_set (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .mac       (req_tdata[REQ_SRC_LO +: MAC_W]),
      .done      (set_done),
      .set_index (set_idx)
   );

   mlf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (set_done),
      .rd_addr (set_idx),
      .rd_data (row)
   );

   // lookup on the row read back for the held item
   always_comb begin
      hit_any  = 1'b0;
      hit_way  = '0;
      free_any = 1'b0;
      free_way = '0;
      for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
         if (row[VALID_LO + w] && (row[w*MAC_W +: MAC_W] == src_ff)) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row[VALID_LO + w]) begin
            free_any = 1'b1;
            free_way = WAY_W'(w);
         end
      end

      short_frame = (len_ff < LEN_W'(MIN_HEADER));
      on_active   = (bond_port_ff != '0) && (port_ff == bond_port_ff);
      learn       = !short_frame && (mode_ff == MODE_EGRESS) && !hit_any;
      refresh     = !short_frame && (mode_ff == MODE_INGRESS) && on_active && hit_any;
      group_drop  = !short_frame && (mode_ff == MODE_INGRESS) && !on_active &&
                    dst_ff[GROUP_BIT];
      evict       = learn && !free_any;

      if (learn) begin
         way_sel = free_any ? free_way : victim_f(row[REC_LO +: RW]);
      end else begin
         way_sel = hit_way;
      end

      row_new = row;
      if (learn) begin
         for (int w = 0; w < TABLE_WAYS; w++) begin
            if (way_sel == WAY_W'(w)) begin
               row_new[w*MAC_W +: MAC_W] = src_ff;
               row_new[VALID_LO + w]     = 1'b1;
            end
         end
      end
      if (LEVELS > 0) begin
         row_new[REC_LO +: RW] = touch_f(row[REC_LO +: RW], way_sel);
      end

      if (refresh) begin
         verdict = VERDICT_DROP_LOOP;
      end else if (group_drop) begin
         verdict = VERDICT_DROP_GROUP;
      end else begin
         verdict = VERDICT_PASS;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = set_ff;
      wr_data = row_new;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == ST_LOOK && out_free && (learn || refresh)) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      set_in         = set_ff;
      mode_in        = mode_ff;
      port_in        = port_ff;
      len_in         = len_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      bond_port_in   = csr_we ? csr_wdata : bond_port_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      if (set_done) begin
         set_in = set_idx;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SET_W'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_tuser;
               port_in  = req_tdata[REQ_PORT_LO +: PORT_W];
               len_in   = req_tdata[REQ_LEN_LO +: LEN_W];
               src_in   = req_tdata[REQ_SRC_LO +: MAC_W];
               dst_in   = req_tdata[REQ_DST_LO +: MAC_W];
               state_in = set_done ? ST_LOOK : ST_DIV;
            end
         end
         ST_DIV: begin
            if (set_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[RSP_VERDICT_LO +: 2] = verdict;
               rsp_data_in[RSP_LEARNED]         = learn;
               rsp_data_in[RSP_EVICTED]         = evict;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         bond_port_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         bond_port_ff   <= bond_port_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      set_ff      <= set_in;
      mode_ff     <= mode_in;
      port_ff     <= port_in;
      len_ff      <= len_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/mlf_checker.sv]
module mlf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mlf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import mlf_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item in flight: no accept on the cycle right after an accept
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while previous item in flight");

   a_evict_learn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_EVICTED] |-> rsp_tdata[RSP_LEARNED])
      else $error("evicted without learned");

   a_learn_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_LEARNED] |->
         rsp_tdata[RSP_VERDICT_LO +: 2] == VERDICT_PASS)
      else $error("learned item with drop verdict");

endmodule

bind mac_loopback_filter_learning mlf_checker u_mlf_checker (.*);
